// ===== design/vcs_pkg.sv =====
// ----------------------------------------------------------------------------
// vcs_pkg
// Shared constants and controller command type for the velocity command
// shaper.
// ----------------------------------------------------------------------------
package vcs_pkg;

	localparam int VEL_WIDTH_DEF  = 16;
	localparam int COEF_FRAC_DEF  = 16;

	localparam int LIM_BITS       = 16;
	localparam int VEL_FRAC       = 12;
	localparam int SCALE_FRAC     = 8;

	localparam int DB_LINEAR      = (8 * (1 << VEL_FRAC) + 50) / 100;
	localparam int DB_ANGULAR     = (17 * (1 << VEL_FRAC) + 50) / 100;
	localparam int TRIG_HALF      = -16384;

	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_SOCCER  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COEF_FIGHT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FWD_MAX      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FWD_MIN      = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_LAT_LIMITS   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_LIMITS   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SCALES       = 3'd7;

	localparam logic [31:0] SCALES_RESET = 32'h0100_0100;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic scale;
		logic fin;
	} vcs_cmd_t;

endpackage

// ===== design/vcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// vcs_ctrl
// Sequencer for the shaper datapath: accepts a request, steps it through
// the multiply, sum and scale steps and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module vcs_ctrl
	import vcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output vcs_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_SUM   = 3'd2;
	localparam logic [2:0] S_SCALE = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       fin_go;
	logic       take_in;

	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == S_FIN) && out_free;
	assign take_in  = (state_q == S_IDLE) || fin_go;
	assign in_stall = !take_in;

	always_comb begin
		cmd.load  = in_valid && take_in;
		cmd.mul   = (state_q == S_MUL);
		cmd.sum   = (state_q == S_SUM);
		cmd.scale = (state_q == S_SCALE);
		cmd.fin   = fin_go;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.load) begin
					state_d = S_MUL;
				end
			end
			S_MUL:   state_d = S_SUM;
			S_SUM:   state_d = S_SCALE;
			S_SCALE: state_d = S_FIN;
			S_FIN: begin
				if (fin_go) begin
					state_d = cmd.load ? S_MUL : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> out_valid)
		else $error("finished request did not raise out_valid");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid && out_stall) |=> (state_q == S_FIN))
		else $error("result overwritten while output stalled");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_MUL))
		else $error("accepted request did not start the multiply step");

	a_out_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !cmd.fin) |=> !out_valid)
		else $error("taken result still shown");
`endif

endmodule

// ===== design/vcs_datapath.sv =====
// ----------------------------------------------------------------------------
// vcs_datapath
// Configuration registers, mode flag, clamping, smoothing, scaling,
// saturation and deadband for the three velocity lanes.
// ----------------------------------------------------------------------------
module vcs_datapath
	import vcs_pkg::*;
#(
	parameter int VEL_WIDTH      = VEL_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vcs_cmd_t                    cmd,
	input  logic                        cfg_write,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic signed [VEL_WIDTH-1:0] cmd_forward,
	input  logic signed [VEL_WIDTH-1:0] cmd_lateral,
	input  logic signed [VEL_WIDTH-1:0] cmd_yaw,
	input  logic signed [15:0]          trigger_value,
	input  logic                        pad_up,
	input  logic                        pad_down,
	output logic signed [VEL_WIDTH-1:0] out_forward,
	output logic signed [VEL_WIDTH-1:0] out_lateral,
	output logic signed [VEL_WIDTH-1:0] out_yaw,
	output logic                        walk_active,
	output logic                        boost_active
);

	localparam int CW  = (VEL_WIDTH > LIM_BITS) ? VEL_WIDTH : LIM_BITS;
	localparam int CFW = COEF_FRAC_BITS + 1;
	localparam int PAW = CW + CFW + 1;
	localparam int PBW = VEL_WIDTH + CFW + 1;
	localparam int PW  = PAW + 1;
	localparam int Y1W = CW + 2;
	localparam int Y2W = Y1W + LIM_BITS;

	localparam logic [CFW-1:0] COEF_ONE = CFW'(1) << COEF_FRAC_BITS;
	localparam logic [CFW-1:0] COEF_BOOST =
		CFW'(((64'd7 << COEF_FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [PW-1:0]  RND_C = PW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [Y2W-1:0] RND_S = Y2W'(1) <<< (SCALE_FRAC - 1);
	localparam logic signed [Y2W-1:0] VMAX_W =
		Y2W'((64'sd1 <<< (VEL_WIDTH - 1)) - 64'sd1);
	localparam logic signed [Y2W-1:0] VMIN_W = -VMAX_W - Y2W'(1);

	function automatic logic signed [CW-1:0] clamp_lh(
		input logic signed [CW-1:0] v,
		input logic signed [CW-1:0] lo,
		input logic signed [CW-1:0] hi
	);
		logic signed [CW-1:0] t;
		t = (v < lo) ? lo : v;
		return (t > hi) ? hi : t;
	endfunction

	function automatic logic [CFW-1:0] coef_sat(input logic [CFW-1:0] c);
		return (c[COEF_FRAC_BITS] && (|c[COEF_FRAC_BITS-1:0])) ? COEF_ONE : c;
	endfunction

	function automatic logic signed [CW-1:0] lim(input logic [LIM_BITS-1:0] f);
		return CW'(signed'(f));
	endfunction

	logic                 control_mode_q;
	logic [CFW-1:0]       coef_soccer_q;
	logic [CFW-1:0]       coef_fight_q;
	logic [63:0]          fwd_max_q;
	logic [31:0]          fwd_min_q;
	logic [31:0]          lat_lim_q;
	logic [31:0]          yaw_lim_q;
	logic [31:0]          scales_q;

	logic                 walk_q;
	logic signed [VEL_WIDTH-1:0] prev_q [3];

	logic                 pressed;
	logic                 press_left;
	logic                 walk_next;
	logic                 boost_next;
	logic signed [CW-1:0] xmax;
	logic signed [CW-1:0] xmin;
	logic [CFW-1:0]       coef_next;
	logic signed [CW-1:0] x_clamp [3];

	logic signed [CW-1:0]  x_s1 [3];
	logic [CFW-1:0]        c_s1;
	logic                  boost_s1;
	logic signed [CFW:0]   c_sg;
	logic signed [CFW:0]   cm_sg;
	logic signed [PAW-1:0] pa_s2 [3];
	logic signed [PBW-1:0] pb_s2 [3];
	logic signed [Y1W-1:0] y1_s3 [3];
	logic signed [Y2W-1:0] y2_s4 [3];
	logic signed [VEL_WIDTH-1:0] fin_val [3];
	logic                  walk_out_q;
	logic                  boost_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_mode_q <= 1'b0;
			coef_soccer_q  <= COEF_ONE;
			coef_fight_q   <= COEF_ONE;
			fwd_max_q      <= '0;
			fwd_min_q      <= '0;
			lat_lim_q      <= '0;
			yaw_lim_q      <= '0;
			scales_q       <= SCALES_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CONTROL_MODE: control_mode_q <= cfg_data[0];
				REG_COEF_SOCCER:  coef_soccer_q  <= cfg_data[CFW-1:0];
				REG_COEF_FIGHT:   coef_fight_q   <= cfg_data[CFW-1:0];
				REG_FWD_MAX:      fwd_max_q      <= cfg_data;
				REG_FWD_MIN:      fwd_min_q      <= cfg_data[31:0];
				REG_LAT_LIMITS:   lat_lim_q      <= cfg_data[31:0];
				REG_YAW_LIMITS:   yaw_lim_q      <= cfg_data[31:0];
				REG_SCALES:       scales_q       <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign pressed = (trigger_value < TRIG_HALF);

	always_comb begin
		walk_next  = walk_q;
		press_left = pressed;
		priority if (pressed && pad_up) begin
			walk_next  = 1'b0;
			press_left = 1'b0;
		end else if (pressed && pad_down) begin
			walk_next  = 1'b1;
			press_left = 1'b0;
		end
	end

	always_comb begin
		xmax       = walk_next ? lim(fwd_max_q[15:0]) : lim(fwd_max_q[31:16]);
		xmin       = walk_next ? lim(fwd_min_q[31:16]) : lim(fwd_min_q[15:0]);
		boost_next = 1'b0;
		if (!control_mode_q) begin
			if (press_left) begin
				xmax       = lim(fwd_max_q[47:32]);
				xmin       = lim(fwd_min_q[15:0]);
				coef_next  = COEF_BOOST;
				boost_next = 1'b1;
			end else begin
				coef_next = coef_sat(coef_soccer_q);
			end
		end else begin
			xmax      = lim(fwd_max_q[63:48]);
			coef_next = coef_sat(coef_fight_q);
		end
		x_clamp[0] = clamp_lh(CW'(cmd_forward), xmin, xmax);
		x_clamp[1] = clamp_lh(CW'(cmd_lateral), lim(lat_lim_q[15:0]),
			lim(lat_lim_q[31:16]));
		x_clamp[2] = clamp_lh(CW'(cmd_yaw), lim(yaw_lim_q[15:0]),
			lim(yaw_lim_q[31:16]));
	end

	assign c_sg  = $signed({1'b0, c_s1});
	assign cm_sg = $signed({1'b0, COEF_ONE - c_s1});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_s1     <= x_clamp;
			c_s1     <= coef_next;
			boost_s1 <= boost_next;
		end
		for (int i = 0; i < 3; i++) begin
			if (cmd.mul) begin
				pa_s2[i] <= x_s1[i] * c_sg;
				pb_s2[i] <= prev_q[i] * cm_sg;
			end
			if (cmd.sum) begin
				y1_s3[i] <= Y1W'((PW'(pa_s2[i]) + PW'(pb_s2[i]) + RND_C)
					>>> COEF_FRAC_BITS);
			end
			if (cmd.scale) begin
				y2_s4[i] <= y1_s3[i] * ((i == 2) ? signed'(scales_q[31:16])
					: signed'(scales_q[15:0]));
			end
		end
		if (cmd.fin) begin
			walk_out_q  <= walk_q;
			boost_out_q <= boost_s1;
		end
	end

	always_comb begin
		logic signed [Y2W-1:0]       r;
		logic signed [VEL_WIDTH-1:0] sv;
		int                          db;
		for (int i = 0; i < 3; i++) begin
			r  = (y2_s4[i] + RND_S) >>> SCALE_FRAC;
			db = (i == 2) ? DB_ANGULAR : DB_LINEAR;
			if (r > VMAX_W) begin
				sv = VMAX_W[VEL_WIDTH-1:0];
			end else if (r < VMIN_W) begin
				sv = VMIN_W[VEL_WIDTH-1:0];
			end else begin
				sv = r[VEL_WIDTH-1:0];
			end
			fin_val[i] = ((int'(sv) < db) && (int'(sv) > -db)) ? '0 : sv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				walk_q <= walk_next;
			end
			if (cmd.fin) begin
				prev_q <= fin_val;
			end
		end
	end

	assign out_forward  = prev_q[0];
	assign out_lateral  = prev_q[1];
	assign out_yaw      = prev_q[2];
	assign walk_active  = walk_out_q;
	assign boost_active = boost_out_q;

endmodule

// ===== design/velocity_command_shaper.sv =====
// A request steps through the multiply, sum and scale steps and a final
// saturation and deadband step before it is shown in the output register.
// The next request is taken while idle or in the cycle its predecessor
// moves into the output register, a move that waits while out_stall holds the shown result.
// Reset: arst_n clears the sequencer, the mode flag, the filter history and
// the configuration registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// velocity_command_shaper
// Joystick velocity shaper: mode selection, clamping, exponential smoothing,
// scaling and deadband for forward, lateral and yaw commands.
// ----------------------------------------------------------------------------
module velocity_command_shaper
	import vcs_pkg::*;
#(
	parameter int VEL_WIDTH      = VEL_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [VEL_WIDTH-1:0] cmd_forward,
	input  logic signed [VEL_WIDTH-1:0] cmd_lateral,
	input  logic signed [VEL_WIDTH-1:0] cmd_yaw,
	input  logic signed [15:0]          trigger_value,
	input  logic                        pad_up,
	input  logic                        pad_down,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [VEL_WIDTH-1:0] out_forward,
	output logic signed [VEL_WIDTH-1:0] out_lateral,
	output logic signed [VEL_WIDTH-1:0] out_yaw,
	output logic                        walk_active,
	output logic                        boost_active,
	input  logic                        cfg_write,
	input  logic [CFG_INDEX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	vcs_cmd_t cmd;

	vcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	vcs_datapath #(
		.VEL_WIDTH      (VEL_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_forward   (cmd_forward),
		.cmd_lateral   (cmd_lateral),
		.cmd_yaw       (cmd_yaw),
		.trigger_value (trigger_value),
		.pad_up        (pad_up),
		.pad_down      (pad_down),
		.out_forward   (out_forward),
		.out_lateral   (out_lateral),
		.out_yaw       (out_yaw),
		.walk_active   (walk_active),
		.boost_active  (boost_active)
	);

endmodule

// ===== test/shaper_book_pkg.sv =====
// ----------------------------------------------------------------------------
// shaper_book_pkg
// Bookkeeping for the velocity command shaper bench. It keeps a bit-exact
// shadow of the configuration, the mode flag and the filter history, and
// works out the shaped command for every accepted request. It also compares
// each shaped command that leaves the block against the oldest one still
// owed.
// ----------------------------------------------------------------------------
package shaper_book_pkg;

	import vcs_pkg::*;

	localparam longint WEIGHT_ONE   = longint'(1) << COEF_FRAC_DEF;
	localparam longint BOOST_WEIGHT = ((longint'(7) << COEF_FRAC_DEF) + 5) / 10;
	localparam longint VEL_MAX      = (longint'(1) << (VEL_WIDTH_DEF - 1)) - 1;
	localparam longint VEL_MIN      = -VEL_MAX - 1;

	typedef struct {
		logic signed [15:0] fwd;
		logic signed [15:0] lat;
		logic signed [15:0] yaw;
		logic               walk;
		logic               boost;
	} shaped_cmd_t;

	class shaped_cmd_book;

		shaped_cmd_t        owed_q[$];
		int                 errors;

		logic               fight_mode;
		logic [16:0]        coef_soccer;
		logic [16:0]        coef_fight;
		logic [63:0]        fwd_max;
		logic [31:0]        fwd_min;
		logic [31:0]        lat_lim;
		logic [31:0]        yaw_lim;
		logic [31:0]        scales;

		logic               walk_mode;
		longint             hist_fwd;
		longint             hist_lat;
		longint             hist_yaw;

		function new();
			errors      = 0;
			fight_mode  = 1'b0;
			coef_soccer = 17'(WEIGHT_ONE);
			coef_fight  = 17'(WEIGHT_ONE);
			fwd_max     = '0;
			fwd_min     = '0;
			lat_lim     = '0;
			yaw_lim     = '0;
			scales      = SCALES_RESET;
			walk_mode   = 1'b0;
			hist_fwd    = 0;
			hist_lat    = 0;
			hist_yaw    = 0;
		endfunction

		function void note_config(input logic [CFG_INDEX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CONTROL_MODE: fight_mode  = data[0];
				REG_COEF_SOCCER:  coef_soccer = data[16:0];
				REG_COEF_FIGHT:   coef_fight  = data[16:0];
				REG_FWD_MAX:      fwd_max     = data;
				REG_FWD_MIN:      fwd_min     = data[31:0];
				REG_LAT_LIMITS:   lat_lim     = data[31:0];
				REG_YAW_LIMITS:   yaw_lim     = data[31:0];
				REG_SCALES:       scales      = data[31:0];
				default: ;
			endcase
		endfunction

		static function longint slot16(input logic [63:0] r, input int k);
			return longint'($signed(r[k*LIM_BITS +: LIM_BITS]));
		endfunction

		static function longint unit_weight(input logic [16:0] r);
			return (longint'(r) > WEIGHT_ONE) ? WEIGHT_ONE : longint'(r);
		endfunction

		static function longint bound(input longint v, input longint lo, input longint hi);
			if (v < lo)
				v = lo;
			if (v > hi)
				v = hi;
			return v;
		endfunction

		static function longint shape_channel(input longint x, input longint prev,
				input longint c, input longint scale, input longint db);
			longint y;
			y = (x * c + prev * (WEIGHT_ONE - c) + (longint'(1) << (COEF_FRAC_DEF - 1)))
				>>> COEF_FRAC_DEF;
			y = (y * scale + (longint'(1) << (SCALE_FRAC - 1))) >>> SCALE_FRAC;
			y = bound(y, VEL_MIN, VEL_MAX);
			if (y < db && y > -db)
				y = 0;
			return y;
		endfunction

		function void note_command(input logic signed [15:0] fwd, lat, yaw, trig,
				input logic up, down);
			shaped_cmd_t e;
			bit          pressed;
			longint      xmax;
			longint      xmin;
			longint      c;
			pressed = int'(trig) < TRIG_HALF;
			if (pressed && up) begin
				walk_mode = 1'b0;
				pressed   = 1'b0;
			end else if (pressed && down) begin
				walk_mode = 1'b1;
				pressed   = 1'b0;
			end
			xmax    = walk_mode ? slot16(fwd_max, 0) : slot16(fwd_max, 1);
			xmin    = walk_mode ? slot16(fwd_min, 1) : slot16(fwd_min, 0);
			e.boost = 1'b0;
			if (!fight_mode) begin
				if (pressed) begin
					xmax    = slot16(fwd_max, 2);
					xmin    = slot16(fwd_min, 0);
					c       = BOOST_WEIGHT;
					e.boost = 1'b1;
				end else begin
					c = unit_weight(coef_soccer);
				end
			end else begin
				xmax = slot16(fwd_max, 3);
				c    = unit_weight(coef_fight);
			end
			hist_fwd = shape_channel(bound(longint'(fwd), xmin, xmax), hist_fwd, c,
				slot16(scales, 0), DB_LINEAR);
			hist_lat = shape_channel(bound(longint'(lat), slot16(lat_lim, 0),
				slot16(lat_lim, 1)), hist_lat, c, slot16(scales, 0), DB_LINEAR);
			hist_yaw = shape_channel(bound(longint'(yaw), slot16(yaw_lim, 0),
				slot16(yaw_lim, 1)), hist_yaw, c, slot16(scales, 1), DB_ANGULAR);
			e.fwd  = hist_fwd[15:0];
			e.lat  = hist_lat[15:0];
			e.yaw  = hist_yaw[15:0];
			e.walk = walk_mode;
			owed_q.push_back(e);
		endfunction

		function void compare(input string name, input logic signed [15:0] want, got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_shaped(input logic signed [15:0] fwd, lat, yaw,
				input logic walk, boost);
			shaped_cmd_t e;
			if (owed_q.size() == 0) begin
				$error("shaped command with no request waiting: fwd %0d lat %0d yaw %0d",
					fwd, lat, yaw);
				errors++;
				return;
			end
			e = owed_q.pop_front();
			compare("out_forward", e.fwd, fwd);
			compare("out_lateral", e.lat, lat);
			compare("out_yaw", e.yaw, yaw);
			compare("walk_active", e.walk, walk);
			compare("boost_active", e.boost, boost);
		endfunction

		function int outstanding();
			return owed_q.size();
		endfunction

	endclass

endpackage

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the velocity command shaper. A directed set of
// requests covers field extremes, deadband edges, trigger thresholds and
// every mode change, then random requests run under register settings from
// tame to extreme. Both sides idle and stall at random except in SET_WIDE.
// Every shaped command is checked field by field against the shadow model.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import vcs_pkg::*;
	import shaper_book_pkg::*;

	localparam int RANDOM_PER_PHASE = 112;

	typedef enum {
		SET_DIRECTED,
		SET_TAME,
		SET_WIDE,
		SET_CROSSED,
		SET_RAW,
		SET_ZERO
	} setting_kind_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [15:0]      cmd_forward;
	logic signed [15:0]      cmd_lateral;
	logic signed [15:0]      cmd_yaw;
	logic signed [15:0]      trigger_value;
	logic                    pad_up;
	logic                    pad_down;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [15:0]      out_forward;
	logic signed [15:0]      out_lateral;
	logic signed [15:0]      out_yaw;
	logic                    walk_active;
	logic                    boost_active;
	logic                    cfg_write;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	bit                      idling = 1'b1;
	shaped_cmd_book          book;

	velocity_command_shaper DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd_forward   (cmd_forward),
		.cmd_lateral   (cmd_lateral),
		.cmd_yaw       (cmd_yaw),
		.trigger_value (trigger_value),
		.pad_up        (pad_up),
		.pad_down      (pad_down),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_forward   (out_forward),
		.out_lateral   (out_lateral),
		.out_yaw       (out_yaw),
		.walk_active   (walk_active),
		.boost_active  (boost_active),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= idling && ($urandom_range(99) < 19);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			book.check_shaped(out_forward, out_lateral, out_yaw, walk_active, boost_active);
	end

	function automatic logic signed [15:0] rand_velocity();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(1600)) - 800);
			default: return 16'(int'($urandom_range(24576)) - 12288);
		endcase
	endfunction

	function automatic logic [31:0] limit_pair(input int span);
		return {16'($urandom_range(span)), -16'($urandom_range(span))};
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		book.note_config(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic send_request(input logic signed [15:0] fwd, lat, yaw, trig,
			input logic up, down);
		@(negedge clk);
		while (idling && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_forward   <= fwd;
		cmd_lateral   <= lat;
		cmd_yaw       <= yaw;
		trigger_value <= trig;
		pad_up        <= up;
		pad_down      <= down;
		in_valid      <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		book.note_command(fwd, lat, yaw, trig, up, down);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.outstanding() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apply_setting(input setting_kind_t kind);
		logic [CFG_DATA_W-1:0] v [8];
		foreach (v[i])
			v[i] = '0;
		case (kind)
			SET_DIRECTED: begin
				v[REG_CONTROL_MODE] = 0;
				v[REG_COEF_SOCCER]  = 65536;
				v[REG_COEF_FIGHT]   = 32768;
				v[REG_FWD_MAX]      = 64'h1800_2000_1000_0800;
				v[REG_FWD_MIN]      = 32'hF800_F000;
				v[REG_LAT_LIMITS]   = 32'h1000_F000;
				v[REG_YAW_LIMITS]   = 32'h2000_E000;
				v[REG_SCALES]       = 32'h0100_0100;
			end
			SET_TAME: begin
				v[REG_CONTROL_MODE] = $urandom_range(1);
				v[REG_COEF_SOCCER]  = $urandom_range(65536);
				v[REG_COEF_FIGHT]   = $urandom_range(65536);
				v[REG_FWD_MAX]      = {16'($urandom_range(4096, 12288)),
					16'($urandom_range(8192, 16384)), 16'($urandom_range(4096, 8192)),
					16'($urandom_range(1024, 4096))};
				v[REG_FWD_MIN]      = {-16'($urandom_range(2048)), -16'($urandom_range(4096))};
				v[REG_LAT_LIMITS]   = limit_pair(8192);
				v[REG_YAW_LIMITS]   = limit_pair(8192);
				v[REG_SCALES]       = {16'($urandom_range(128, 768)),
					16'($urandom_range(128, 768))};
			end
			SET_WIDE: begin
				v[REG_CONTROL_MODE] = 1;
				v[REG_COEF_SOCCER]  = 0;
				v[REG_COEF_FIGHT]   = 17'h10001;
				v[REG_FWD_MAX]      = 64'h7FFF_7FFF_7FFF_7FFF;
				v[REG_FWD_MIN]      = 32'h8000_8000;
				v[REG_LAT_LIMITS]   = 32'h7FFF_8000;
				v[REG_YAW_LIMITS]   = 32'h7FFF_8000;
				v[REG_SCALES]       = 32'h7FFF_0100;
			end
			SET_CROSSED: begin
				v[REG_CONTROL_MODE] = 0;
				v[REG_COEF_SOCCER]  = 17'h1FFFF;
				v[REG_COEF_FIGHT]   = 0;
				v[REG_FWD_MAX]      = 64'h0100_0100_0100_0100;
				v[REG_FWD_MIN]      = 32'h2000_2000;
				v[REG_LAT_LIMITS]   = 32'hF000_1000;
				v[REG_YAW_LIMITS]   = 32'hE000_2000;
				v[REG_SCALES]       = 32'h8000_8000;
			end
			SET_RAW: begin
				foreach (v[i])
					v[i] = {$urandom, $urandom};
			end
			SET_ZERO: begin
				v[REG_CONTROL_MODE] = 0;
			end
			default: ;
		endcase
		foreach (v[i])
			write_reg(CFG_INDEX_W'(i), v[i]);
	endtask

	initial begin
		setting_kind_t      plan [8];
		logic signed [15:0] trig;
		book          = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd_forward   = '0;
		cmd_lateral   = '0;
		cmd_yaw       = '0;
		trigger_value = '0;
		pad_up        = 1'b0;
		pad_down      = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		plan = '{SET_TAME, SET_WIDE, SET_CROSSED, SET_RAW, SET_TAME, SET_ZERO,
			SET_RAW, SET_TAME};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		apply_setting(SET_DIRECTED);
		send_request(0, 0, 0, 0, 0, 0);
		send_request(32767, 32767, 32767, 0, 0, 0);
		send_request(-32768, -32768, -32768, 32767, 0, 0);
		send_request(327, -327, 695, 0, 0, 0);
		send_request(328, -328, 696, 0, 0, 0);
		send_request(2048, 1024, 512, TRIG_HALF, 1, 1);
		send_request(28672, 256, 256, TRIG_HALF - 1, 0, 0);
		send_request(28672, 0, 0, -32768, 0, 1);
		send_request(28672, -28672, 0, 0, 0, 0);
		send_request(-28672, 0, 0, 0, 0, 0);
		send_request(28672, 0, 0, -20000, 0, 0);
		send_request(4096, 0, 0, -20000, 1, 1);
		send_request(-28672, 0, 0, 0, 1, 1);
		drain();
		write_reg(REG_CONTROL_MODE, 1);
		send_request(28672, 0, 0, -20000, 0, 0);
		send_request(-28672, 0, 0, -30000, 0, 1);
		send_request(28672, 0, 0, 0, 0, 0);
		send_request(16384, 0, 0, -30000, 1, 0);
		send_request(-32768, 0, 0, 0, 0, 0);

		foreach (plan[p]) begin
			drain();
			apply_setting(plan[p]);
			idling = (plan[p] != SET_WIDE);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n == RANDOM_PER_PHASE / 2)
					drain();
				case ($urandom_range(9))
					0, 1, 2, 3: trig = 16'(TRIG_HALF - 1 - int'($urandom_range(16383)));
					4: trig = ($urandom_range(1) != 0) ? 16'(TRIG_HALF) : 16'(TRIG_HALF - 1);
					default: trig = 16'($urandom);
				endcase
				send_request(rand_velocity(), rand_velocity(), rand_velocity(), trig,
					$urandom_range(99) < 30, $urandom_range(99) < 30);
			end
		end
		drain();

		if (book.errors == 0 && book.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== velocity_command_shaper.f =====
design/vcs_pkg.sv
design/vcs_ctrl.sv
design/vcs_datapath.sv
design/velocity_command_shaper.sv
test/shaper_book_pkg.sv
test/tb_top.sv
